>>> rtl/bbpg_pkg.sv
// Shared widths, register indices, mode codes and beat types of the pulse generator.
package bbpg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TIMER_W    = 20;
    localparam int DUR_W      = 16;
    localparam int MODE_W     = 2;
    localparam int PINS_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE   = 3'd6;

    localparam logic [MODE_W-1:0] MODE_ALT       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYNC      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLANK     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALT_ALIAS = 2'd3;

    localparam logic [TIMER_W-1:0] CYCLE_RESET   = 20'd1000000;
    localparam logic [TIMER_W-1:0] MS_REST_RESET = 20'd1000000;

    // Whole milliseconds via reciprocal: floor(x / 1000) = (x * 1073742) >> 30 for 20-bit x.
    localparam int MS_RECIP_W = 21;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP = 21'd1073742;
    localparam int MS_SHIFT = 30;
    localparam int MS_Q_W   = 11;

    typedef struct packed {
        logic                enable;
        logic [MODE_W-1:0]   mode;
        logic [DUR_W-1:0]    dead;
        logic [DUR_W-1:0]    half;
        logic [DUR_W-1:0]    pulses;
        logic [DUR_W-1:0]    gap;
        logic [TIMER_W-1:0]  cycle;
        logic [TIMER_W-1:0]  ms_rest;
    } t_cfg;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic              start;
    } t_result;

endpackage

>>> rtl/bbpg_ifs.sv
// Valid/ready channel interfaces for the tick input and the pin level output.
interface bbpg_in_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

interface bbpg_out_if;
    logic valid;
    logic ready;
    logic group1_pos;
    logic group1_neg;
    logic group2_pos;
    logic group2_neg;
    logic cycle_start;

    modport source (
        output valid, output group1_pos, output group1_neg,
        output group2_pos, output group2_neg, output cycle_start,
        input ready
    );
    modport sink (
        input valid, input group1_pos, input group1_neg,
        input group2_pos, input group2_neg, input cycle_start,
        output ready
    );
endinterface

>>> rtl/bbpg_cfg.sv
// Configuration registers with the derived half phase and millisecond rest.
module bbpg_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we,
    input  logic [bbpg_pkg::CFG_IDX_W-1:0]     i_idx,
    input  logic [bbpg_pkg::CFG_DATA_W-1:0]    i_data,
    output bbpg_pkg::t_cfg                     o_cfg
);
    import bbpg_pkg::*;

    logic                  r_enable;
    logic [MODE_W-1:0]     r_mode;
    logic [DUR_W-1:0]      r_carrier;
    logic [DUR_W-1:0]      r_dead;
    logic [DUR_W-1:0]      r_pulses;
    logic [DUR_W-1:0]      r_gap;
    logic [TIMER_W-1:0]    r_cycle;
    logic [TIMER_W-1:0]    r_ms_rest;

    logic [TIMER_W+MS_RECIP_W-1:0] w_prod;
    logic [MS_Q_W-1:0]             w_ms_q;
    logic [TIMER_W:0]              w_ms_full;
    logic [DUR_W:0]                w_twice;
    logic [DUR_W:0]                w_diff;

    assign w_prod    = (TIMER_W+MS_RECIP_W)'(i_data) * (TIMER_W+MS_RECIP_W)'(MS_RECIP);
    assign w_ms_q    = w_prod[MS_SHIFT +: MS_Q_W];
    assign w_ms_full = {w_ms_q, 10'd0} - (TIMER_W+1)'({w_ms_q, 4'd0})
                       - (TIMER_W+1)'({w_ms_q, 3'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_mode    <= MODE_ALT;
            r_carrier <= '0;
            r_dead    <= '0;
            r_pulses  <= '0;
            r_gap     <= '0;
            r_cycle   <= CYCLE_RESET;
            r_ms_rest <= MS_REST_RESET;
        end else if (i_we) begin
            unique case (i_idx)
                REG_ENABLE:  r_enable  <= i_data[0];
                REG_MODE:    r_mode    <= i_data[MODE_W-1:0];
                REG_CARRIER: r_carrier <= i_data[DUR_W-1:0];
                REG_DEAD:    r_dead    <= i_data[DUR_W-1:0];
                REG_PULSES:  r_pulses  <= i_data[DUR_W-1:0];
                REG_GAP:     r_gap     <= i_data[DUR_W-1:0];
                REG_CYCLE: begin
                    r_cycle   <= i_data[TIMER_W-1:0];
                    r_ms_rest <= w_ms_full[TIMER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_twice = {r_dead, 1'b0};
    assign w_diff  = {1'b0, r_carrier} - w_twice;

    always_comb begin
        o_cfg         = '0;
        o_cfg.enable  = r_enable;
        o_cfg.mode    = r_mode;
        o_cfg.dead    = r_dead;
        o_cfg.half    = ({1'b0, r_carrier} > w_twice) ? w_diff[DUR_W:1] : '0;
        o_cfg.pulses  = r_pulses;
        o_cfg.gap     = r_gap;
        o_cfg.cycle   = r_cycle;
        o_cfg.ms_rest = r_ms_rest;
    end

endmodule

>>> rtl/bbpg_core.sv
// Segment state of the pulse sequence and its single-pass update per tick.
module bbpg_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bbpg_pkg::t_cfg     i_cfg,
    input  logic               i_step,
    input  logic               i_tick,
    output bbpg_pkg::t_result  o_result
);
    import bbpg_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_POS  = 3'd1;
    localparam logic [2:0] PH_DEAD = 3'd2;
    localparam logic [2:0] PH_NEG  = 3'd3;
    localparam logic [2:0] PH_GAP  = 3'd4;
    localparam logic [2:0] PH_REST = 3'd5;

    // No tick ever passes more than seven empty segments.
    localparam int RESOLVE_STEPS = 8;

    typedef struct packed {
        logic [2:0]          phase;
        logic                group;
        logic [DUR_W-1:0]    count;
        logic [TIMER_W-1:0]  timer;
        logic [TIMER_W-1:0]  elapsed;
        logic [MODE_W-1:0]   cmode;
    } t_seg;

    t_seg                r_seg;
    logic [PINS_W-1:0]   r_pins;
    t_seg                n_seg;
    logic [PINS_W-1:0]   n_pins;

    t_seg                w_seg;
    logic                w_start;
    logic                w_empty;
    logic                w_done;
    logic [PINS_W-1:0]   w_pins;
    logic                w_pos;
    logic                w_neg;
    logic                w_g1;
    logic                w_g2;

    function automatic t_seg burst_end(t_seg s, t_cfg c);
        t_seg r;
        r = s;
        if (s.cmode == MODE_ALT && !s.group) begin
            r.phase = PH_GAP;
            r.timer = TIMER_W'(c.gap);
        end else if (s.cmode == MODE_ALT) begin
            r.phase = PH_REST;
            r.timer = (c.cycle > s.elapsed) ? c.cycle - s.elapsed : '0;
        end else begin
            r.phase = PH_REST;
            r.timer = c.ms_rest;
        end
        return r;
    endfunction

    function automatic t_seg burst_begin(t_seg s, t_cfg c);
        t_seg r;
        r = s;
        r.count = '0;
        if (c.pulses == '0 || (c.half == '0 && c.dead == '0)) begin
            r.count = c.pulses;
            r = burst_end(r, c);
        end else begin
            r.phase = PH_POS;
            r.timer = TIMER_W'(c.half);
        end
        return r;
    endfunction

    function automatic t_seg cycle_begin(t_seg s, t_cfg c);
        t_seg r;
        r = s;
        r.cmode   = (c.mode == MODE_ALT_ALIAS) ? MODE_ALT : c.mode;
        r.group   = 1'b0;
        r.elapsed = '0;
        if (r.cmode == MODE_BLANK) begin
            r.phase = PH_REST;
            r.timer = c.ms_rest;
        end else begin
            r = burst_begin(r, c);
        end
        return r;
    endfunction

    function automatic t_seg advance(t_seg s, t_cfg c);
        t_seg r;
        r = s;
        unique case (s.phase)
            PH_POS: begin
                r.phase = PH_DEAD;
                r.timer = TIMER_W'(c.dead);
            end
            PH_DEAD: begin
                r.phase = PH_NEG;
                r.timer = TIMER_W'(c.half);
            end
            PH_NEG: begin
                // With no half phase and no dead time the remaining pulses are all empty.
                if (c.half == '0 && c.dead == '0) begin
                    r = burst_end(s, c);
                end else begin
                    r.count = s.count + DUR_W'(1);
                    if (r.count < c.pulses) begin
                        r.phase = PH_POS;
                        r.timer = TIMER_W'(c.half);
                    end else begin
                        r = burst_end(r, c);
                    end
                end
            end
            PH_GAP: begin
                r.group   = 1'b1;
                r.elapsed = '0;
                r = burst_begin(r, c);
            end
            default: begin
                r = cycle_begin(s, c);
            end
        endcase
        return r;
    endfunction

    always_comb begin
        w_seg   = r_seg;
        w_start = 1'b0;
        w_empty = 1'b0;
        w_done  = 1'b0;
        if (w_seg.phase == PH_IDLE) begin
            w_seg   = cycle_begin(w_seg, i_cfg);
            w_start = 1'b1;
        end
        for (int k = 0; k < RESOLVE_STEPS; k++) begin
            if (!w_done) begin
                if (w_seg.timer != '0) begin
                    w_done = 1'b1;
                end else if (w_start && w_seg.phase == PH_REST) begin
                    w_empty = 1'b1;
                    w_done  = 1'b1;
                end else begin
                    if (w_seg.phase == PH_REST) begin
                        w_start = 1'b1;
                    end
                    w_seg = advance(w_seg, i_cfg);
                end
            end
        end

        w_pos = (w_seg.phase == PH_POS);
        w_neg = (w_seg.phase == PH_NEG);
        w_g1  = (w_seg.cmode == MODE_SYNC) || !w_seg.group;
        w_g2  = (w_seg.cmode == MODE_SYNC) || w_seg.group;
        w_pins = '0;
        if (!w_empty) begin
            w_pins      = {w_neg & w_g2, w_pos & w_g2, w_neg & w_g1, w_pos & w_g1};
            w_seg.timer = w_seg.timer - TIMER_W'(1);
        end
        if (w_seg.elapsed != '1) begin
            w_seg.elapsed = w_seg.elapsed + TIMER_W'(1);
        end
    end

    always_comb begin
        n_seg  = r_seg;
        n_pins = r_pins;
        o_result.pins  = r_pins;
        o_result.start = 1'b0;
        if (!i_cfg.enable) begin
            n_seg.phase   = PH_IDLE;
            n_seg.group   = 1'b0;
            n_seg.count   = '0;
            n_seg.timer   = '0;
            n_seg.elapsed = '0;
            n_pins        = '0;
            o_result.pins = '0;
        end else if (i_tick) begin
            n_seg          = w_seg;
            n_pins         = w_pins;
            o_result.pins  = w_pins;
            o_result.start = w_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg  <= '0;
            r_pins <= '0;
        end else if (i_step) begin
            r_seg  <= n_seg;
            r_pins <= n_pins;
        end
    end

    a_resolve_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_cfg.enable && i_tick) |-> w_done)
        else $error("segment chain not settled within the resolve steps");

    a_pins_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pins[0] && r_pins[1]) && !(r_pins[2] && r_pins[3]))
        else $error("positive and negative pins of one group driven together");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seg.phase == PH_IDLE) |-> (r_pins == '0))
        else $error("pins driven while idle");

endmodule

>>> rtl/bbpg_obuf.sv
// Two-entry output buffer holding result beats for the output channel.
module bbpg_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bbpg_pkg::t_result  i_data,
    output logic               o_ready,
    bbpg_out_if.source         o_out
);
    import bbpg_pkg::*;

    logic     r_out_valid;
    logic     r_skid_valid;
    t_result  r_out;
    t_result  r_skid;
    logic     n_out_valid;
    logic     n_skid_valid;
    t_result  n_out;
    t_result  n_skid;
    logic     w_pop;

    assign w_pop   = r_out_valid & o_out.ready;
    assign o_ready = !r_skid_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_pop || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = i_push;
                n_skid       = i_data;
            end else begin
                n_out_valid = i_push;
                n_out       = i_data;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.group1_pos  = r_out.pins[0];
    assign o_out.group1_neg  = r_out.pins[1];
    assign o_out.group2_pos  = r_out.pins[2];
    assign o_out.group2_neg  = r_out.pins[3];
    assign o_out.cycle_start = r_out.start;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("second entry full while the output entry is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_out.ready))
        else $error("second entry filled without an output stall");

    a_refill_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && r_skid_valid) |=> r_out_valid)
        else $error("waiting beat lost after output taken");

endmodule

>>> rtl/bipolar_burst_pulse_generator.sv
// Top level of the bipolar burst pulse generator.
//
//  Channel  Direction  Beat contents                                   Handshake
//  i_in     in         tick                                            valid/ready
//  o_out    out        group1_pos group1_neg group2_pos group2_neg     valid/ready
//                      cycle_start
//  i_cfg_*  in         register index and data                         write enable
//
// One beat is accepted per clock cycle while ready is high; its result is buffered.
// The whole segment update for a tick is settled in one pass through the state logic.
// A two-entry output buffer lets input beats be taken while a result waits.
// Input ready falls only when both buffer entries are full.
// Reset is synchronous and active low; there is no clearing pass.
module bipolar_burst_pulse_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    bbpg_in_if.sink                            i_in,
    bbpg_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [bbpg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bbpg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bbpg_pkg::*;

    t_cfg     w_cfg;
    t_result  w_result;
    logic     w_ready;
    logic     w_step;

    assign i_in.ready = w_ready;
    assign w_step     = i_in.valid & w_ready;

    bbpg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    bbpg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_step),
        .i_tick   (i_in.tick),
        .o_result (w_result)
    );

    bbpg_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_step),
        .i_data  (w_result),
        .o_ready (w_ready),
        .o_out   (o_out)
    );

endmodule

>>> verif/bipolar_burst_pulse_generator_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the pin levels of the pulse generator and compares every output beat.
module bipolar_burst_pulse_generator_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bbpg_in_if                              i_tick_ch,
    bbpg_out_if                             i_pins_ch,
    input  logic                            i_cfg_we,
    input  logic [bbpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import bbpg_pkg::*;

    localparam int US_PER_MS = 1000;
    localparam int REPORT_MAX = 10;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    typedef enum logic [2:0] {
        SEG_IDLE, SEG_POS, SEG_DEAD, SEG_NEG, SEG_GAP, SEG_REST
    } t_segment;

    logic               cfg_enable;
    logic [MODE_W-1:0]  cfg_mode;
    logic [DUR_W-1:0]   cfg_carrier;
    logic [DUR_W-1:0]   cfg_dead;
    logic [DUR_W-1:0]   cfg_pulses;
    logic [DUR_W-1:0]   cfg_gap;
    logic [TIMER_W-1:0] cfg_cycle;

    t_segment           seg;
    logic [MODE_W-1:0]  cycle_mode;
    logic               grp;
    logic [DUR_W-1:0]   pulse_cnt;
    logic [TIMER_W-1:0] seg_timer;
    logic [TIMER_W-1:0] elapsed_us;
    logic [PINS_W-1:0]  pin_levels;

    t_result expected_pins_q[$];
    int      mismatches = 0;

    function automatic logic [TIMER_W-1:0] half_width();
        logic [DUR_W:0]     twice;
        logic [TIMER_W-1:0] half;
        twice = {cfg_dead, 1'b0};
        half = '0;
        if ({1'b0, cfg_carrier} > twice)
            half = TIMER_W'(({1'b0, cfg_carrier} - twice) >> 1);
        return half;
    endfunction

    function automatic logic [TIMER_W-1:0] whole_ms_rest();
        return TIMER_W'((cfg_cycle / US_PER_MS) * US_PER_MS);
    endfunction

    function automatic void end_burst();
        if (cycle_mode == MODE_ALT && !grp) begin
            seg = SEG_GAP;
            seg_timer = TIMER_W'(cfg_gap);
        end else if (cycle_mode == MODE_ALT) begin
            seg = SEG_REST;
            seg_timer = (cfg_cycle > elapsed_us) ? cfg_cycle - elapsed_us : '0;
        end else begin
            seg = SEG_REST;
            seg_timer = whole_ms_rest();
        end
    endfunction

    function automatic void begin_burst();
        pulse_cnt = '0;
        if (cfg_pulses == 0 || (half_width() == 0 && cfg_dead == 0)) begin
            pulse_cnt = cfg_pulses;
            end_burst();
        end else begin
            seg = SEG_POS;
            seg_timer = half_width();
        end
    endfunction

    function automatic void begin_cycle();
        cycle_mode = (cfg_mode == MODE_ALT_ALIAS) ? MODE_ALT : cfg_mode;
        grp = 1'b0;
        elapsed_us = '0;
        if (cycle_mode == MODE_BLANK) begin
            seg = SEG_REST;
            seg_timer = whole_ms_rest();
        end else begin
            begin_burst();
        end
    endfunction

    function automatic logic next_segment();
        logic wrapped;
        wrapped = 1'b0;
        case (seg)
            SEG_POS: begin
                seg = SEG_DEAD;
                seg_timer = TIMER_W'(cfg_dead);
            end
            SEG_DEAD: begin
                seg = SEG_NEG;
                seg_timer = half_width();
            end
            SEG_NEG: begin
                pulse_cnt = pulse_cnt + DUR_W'(1);
                if (pulse_cnt < cfg_pulses) begin
                    seg = SEG_POS;
                    seg_timer = half_width();
                end else begin
                    end_burst();
                end
            end
            SEG_GAP: begin
                grp = 1'b1;
                elapsed_us = '0;
                begin_burst();
            end
            default: begin
                begin_cycle();
                wrapped = 1'b1;
            end
        endcase
        return wrapped;
    endfunction

    function automatic t_result predict_pins(logic tick);
        t_result r;
        logic    started;
        logic    empty;
        logic    pos;
        logic    neg;
        started = 1'b0;
        empty = 1'b0;
        if (!cfg_enable) begin
            seg = SEG_IDLE;
            grp = 1'b0;
            pulse_cnt = '0;
            seg_timer = '0;
            elapsed_us = '0;
            pin_levels = '0;
        end else if (tick) begin
            if (seg == SEG_IDLE) begin
                begin_cycle();
                started = 1'b1;
            end
            while (seg_timer == 0 && !empty) begin
                if (started && seg == SEG_REST)
                    empty = 1'b1;
                else if (next_segment())
                    started = 1'b1;
            end
            pin_levels = '0;
            if (!empty) begin
                pos = (seg == SEG_POS);
                neg = (seg == SEG_NEG);
                if (cycle_mode == MODE_SYNC || !grp)
                    pin_levels[1:0] = {neg, pos};
                if (cycle_mode == MODE_SYNC || grp)
                    pin_levels[3:2] = {neg, pos};
                seg_timer = seg_timer - TIMER_W'(1);
            end
            if (elapsed_us != TIMER_MAX)
                elapsed_us = elapsed_us + TIMER_W'(1);
        end
        r.pins = pin_levels;
        r.start = started;
        return r;
    endfunction

    function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ENABLE:  cfg_enable = data[0];
            REG_MODE:    cfg_mode = data[MODE_W-1:0];
            REG_CARRIER: cfg_carrier = data[DUR_W-1:0];
            REG_DEAD:    cfg_dead = data[DUR_W-1:0];
            REG_PULSES:  cfg_pulses = data[DUR_W-1:0];
            REG_GAP:     cfg_gap = data[DUR_W-1:0];
            REG_CYCLE:   cfg_cycle = data[TIMER_W-1:0];
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg_enable = 1'b0;
            cfg_mode = MODE_ALT;
            cfg_carrier = '0;
            cfg_dead = '0;
            cfg_pulses = '0;
            cfg_gap = '0;
            cfg_cycle = CYCLE_RESET;
            seg = SEG_IDLE;
            cycle_mode = MODE_ALT;
            grp = 1'b0;
            pulse_cnt = '0;
            seg_timer = '0;
            elapsed_us = '0;
            pin_levels = '0;
            expected_pins_q.delete();
        end else begin
            if (i_tick_ch.valid === 1'b1 && i_tick_ch.ready === 1'b1)
                expected_pins_q.push_back(predict_pins(i_tick_ch.tick));
            if (i_cfg_we === 1'b1)
                write_register(i_cfg_idx, i_cfg_data);
            if (i_pins_ch.valid === 1'b1 && i_pins_ch.ready === 1'b1) begin
                got.pins = {i_pins_ch.group2_neg, i_pins_ch.group2_pos,
                            i_pins_ch.group1_neg, i_pins_ch.group1_pos};
                got.start = i_pins_ch.cycle_start;
                if (expected_pins_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected pin beat, pins %b start %b",
                                 $time, got.pins, got.start);
                end else begin
                    want = expected_pins_q.pop_front();
                    if (got.pins !== want.pins || got.start !== want.start) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: expected pins %b start %b, got pins %b start %b",
                                     $time, want.pins, want.start, got.pins, got.start);
                    end
                end
            end
        end
        o_pending <= expected_pins_q.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> verif/bipolar_burst_pulse_generator_test.sv
`timescale 1ns / 1ps
// Testbench top: drives ticks and register writes into the pulse generator and gives the verdict.
module bipolar_burst_pulse_generator_test;
    import bbpg_pkg::*;

    localparam int RANDOM_BEATS = 1350;
    localparam int CALM_BEATS = 250;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct {
        logic               enable;
        logic [MODE_W-1:0]  mode;
        logic [DUR_W-1:0]   carrier;
        logic [DUR_W-1:0]   dead;
        logic [DUR_W-1:0]   pulses;
        logic [DUR_W-1:0]   gap;
        logic [TIMER_W-1:0] cycle;
    } t_setting;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;
    int                    beats;
    bit                    idle_on = 1'b1;

    bbpg_in_if  tick_ch ();
    bbpg_out_if pins_ch ();

    bipolar_burst_pulse_generator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_ch),
        .o_out      (pins_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    bipolar_burst_pulse_generator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_ch    (tick_ch),
        .i_pins_ch    (pins_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("bipolar_burst_pulse_generator_test NOT OK");
            $finish;
        end
    end

    initial begin : sink_pacing
        int stall;
        stall = 0;
        pins_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall != 0) begin
                pins_ch.ready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                pins_ch.ready <= 1'b0;
                stall = $urandom_range(0, 5);
            end else begin
                pins_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input logic t);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.tick <= t;
        @(posedge i_clk);
        while (tick_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic drain();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input int width);
        logic [CFG_DATA_W-1:0] word;
        word = val;
        if ($urandom_range(0, 1) == 1)
            for (int b = width; b < CFG_DATA_W; b++) word[b] = 1'($urandom_range(0, 1));
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= word;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input t_setting s, input bit every);
        put_reg(REG_ENABLE, CFG_DATA_W'(s.enable), 1);
        if (every || $urandom_range(0, 3) != 0)
            put_reg(REG_MODE, CFG_DATA_W'(s.mode), MODE_W);
        if (every || $urandom_range(0, 3) != 0)
            put_reg(REG_CARRIER, CFG_DATA_W'(s.carrier), DUR_W);
        if (every || $urandom_range(0, 3) != 0)
            put_reg(REG_DEAD, CFG_DATA_W'(s.dead), DUR_W);
        if (every || $urandom_range(0, 3) != 0)
            put_reg(REG_PULSES, CFG_DATA_W'(s.pulses), DUR_W);
        if (every || $urandom_range(0, 3) != 0)
            put_reg(REG_GAP, CFG_DATA_W'(s.gap), DUR_W);
        if (every || $urandom_range(0, 3) != 0)
            put_reg(REG_CYCLE, CFG_DATA_W'(s.cycle), TIMER_W);
        cfg_we <= 1'b0;
    endtask

    task automatic clear_state();
        put_reg(REG_ENABLE, '0, 1);
        cfg_we <= 1'b0;
        send_tick(1'b1);
        drain();
    endtask

    function automatic t_setting make_setting(input logic en, input logic [MODE_W-1:0] md,
                                              input logic [DUR_W-1:0] car, dd, pl, gp,
                                              input logic [TIMER_W-1:0] cy);
        t_setting s;
        s.enable = en;
        s.mode = md;
        s.carrier = car;
        s.dead = dd;
        s.pulses = pl;
        s.gap = gp;
        s.cycle = cy;
        return s;
    endfunction

    function automatic t_setting random_setting();
        t_setting s;
        s.enable = ($urandom_range(0, 9) != 0);
        s.mode = MODE_W'($urandom_range(0, 3));
        s.carrier = DUR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 16));
        s.dead = DUR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 4));
        s.pulses = ($urandom_range(0, 19) == 0) ? 16'hFFFF : DUR_W'($urandom_range(0, 4));
        s.gap = DUR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 8));
        case ($urandom_range(0, 19))
            0, 1, 2: s.cycle = TIMER_W'($urandom_range(1000, 2500));
            3, 4:    s.cycle = TIMER_W'($urandom_range(0, 1048575));
            5:       s.cycle = CYCLE_RESET;
            default: s.cycle = TIMER_W'($urandom_range(0, 60));
        endcase
        return s;
    endfunction

    initial begin : stimulus
        t_setting s;
        int       n;
        bit       first;
        tick_ch.valid = 1'b0;
        tick_ch.tick = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset the block is disabled, so every beat reads all pins off.
        send_tick(1'b1);
        send_tick(1'b0);
        drain();

        put_reg(REG_SPARE, '1, CFG_DATA_W);
        program_regs(make_setting(1'b1, MODE_ALT, 16'd4, 16'd1, 16'd1, 16'd1, 20'd4), 1'b1);
        for (int i = 0; i < 9; i++) send_tick(i != 3);
        drain();

        program_regs(make_setting(1'b1, MODE_ALT, '0, '0, '0, '0, '0), 1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();

        clear_state();
        program_regs(make_setting(1'b1, MODE_ALT_ALIAS, '1, '1, '1, '1, CYCLE_RESET), 1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();

        clear_state();
        program_regs(make_setting(1'b1, MODE_SYNC, '1, '0, '1, '0, '1), 1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();

        clear_state();
        program_regs(make_setting(1'b1, MODE_BLANK, 16'd8, 16'd2, 16'd2, 16'd3, 20'd999), 1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();

        beats = 0;
        first = 1'b1;
        while (beats < RANDOM_BEATS) begin
            s = random_setting();
            program_regs(s, first);
            first = 1'b0;
            idle_on = (beats < RANDOM_BEATS - CALM_BEATS) && ($urandom_range(0, 3) != 0);
            n = $urandom_range(20, 120);
            repeat (n) send_tick($urandom_range(0, 4) != 0);
            beats += n;
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("bipolar_burst_pulse_generator_test OK");
        else
            $display("bipolar_burst_pulse_generator_test NOT OK");
        $finish;
    end

endmodule
